/* sv/tss_pkg.sv */
// tss_pkg: shared opcodes, status codes and result metadata type for the
// two-stacks-in-one-array block. No dependencies.
package tss_pkg;

    localparam int unsigned OpW   = 2;
    localparam int unsigned StW   = 2;
    localparam int unsigned WordW = 32;
    localparam int unsigned CntW  = 7;   // width of the count fields on the ports

    localparam logic [OpW-1:0] OP_PUSH  = 2'd0;
    localparam logic [OpW-1:0] OP_POP   = 2'd1;
    localparam logic [OpW-1:0] OP_TOP   = 2'd2;
    localparam logic [OpW-1:0] OP_CLEAR = 2'd3;

    localparam logic [StW-1:0] ST_OK    = 2'd0;
    localparam logic [StW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StW-1:0] ST_FULL  = 2'd2;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // Everything about one result except the word read from the store.
    typedef struct packed {
        logic [StW-1:0]  status;
        logic            use_rd;
        logic            left_empty;
        logic            right_empty;
        logic [CntW-1:0] left_count;
        logic [CntW-1:0] right_count;
    } t_res_meta;

endpackage

/* sv/tss_mem.sv */
// tss_mem: single-port synchronous word store with registered read.
// Uses tss_pkg for the word width.
module tss_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_addr,
    input  logic [tss_pkg::WordW-1:0]   i_wdata,
    output logic [tss_pkg::WordW-1:0]   o_rdata
);
    import tss_pkg::*;

    logic [WordW-1:0] r_mem [DEPTH];
    logic [WordW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/tss_ctrl.sv */
// tss_ctrl: stack depth registers, opcode decode and store access generation.
// Uses tss_pkg for opcodes, status codes and t_res_meta.
module tss_ctrl #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned CW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [tss_pkg::OpW-1:0]     i_opcode,
    input  logic                        i_side_sel,
    output logic                        o_mem_we,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_addr,
    output tss_pkg::t_res_meta          o_meta
);
    import tss_pkg::*;

    localparam logic [CW-1:0] DepthC = CW'(DEPTH);
    localparam logic [CW-1:0] OneC   = CW'(1);

    logic [CW-1:0] r_left;
    logic [CW-1:0] r_right;
    logic [CW-1:0] n_left;
    logic [CW-1:0] n_right;
    logic [CW-1:0] cur_cnt;
    logic [CW:0]   sum_cnt;
    logic          is_full;
    logic          cur_zero;
    logic [CW-1:0] addr_w;
    logic [CW+CntW-1:0] left_ext;
    logic [CW+CntW-1:0] right_ext;

    assign cur_cnt  = (i_side_sel == SIDE_RIGHT) ? r_right : r_left;
    assign sum_cnt  = {1'b0, r_left} + {1'b0, r_right};
    assign is_full  = (sum_cnt >= {1'b0, DepthC});
    assign cur_zero = (cur_cnt == '0);

    always_comb begin
        n_left        = r_left;
        n_right       = r_right;
        o_mem_we      = 1'b0;
        o_mem_re      = 1'b0;
        addr_w        = '0;
        o_meta.status = ST_OK;
        o_meta.use_rd = 1'b0;
        unique case (i_opcode)
            OP_PUSH: begin
                if (is_full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_mem_we = i_accept;
                    if (i_side_sel == SIDE_RIGHT) begin
                        addr_w  = DepthC - OneC - r_right;
                        n_right = r_right + OneC;
                    end else begin
                        addr_w = r_left;
                        n_left = r_left + OneC;
                    end
                end
            end
            OP_POP, OP_TOP: begin
                if (cur_zero) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_mem_re      = i_accept;
                    o_meta.use_rd = 1'b1;
                    if (i_side_sel == SIDE_RIGHT) begin
                        addr_w = DepthC - r_right;
                        if (i_opcode == OP_POP) begin
                            n_right = r_right - OneC;
                        end
                    end else begin
                        addr_w = r_left - OneC;
                        if (i_opcode == OP_POP) begin
                            n_left = r_left - OneC;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                if (i_side_sel == SIDE_RIGHT) begin
                    n_right = '0;
                end else begin
                    n_left = '0;
                end
            end
            default: begin
                o_meta.status = ST_OK;
            end
        endcase

        // Counts on the ports are the low bits of the depth counters.
        left_ext           = {{CntW{1'b0}}, n_left};
        right_ext          = {{CntW{1'b0}}, n_right};
        o_meta.left_count  = left_ext[CntW-1:0];
        o_meta.right_count = right_ext[CntW-1:0];
        o_meta.left_empty  = (n_left == '0);
        o_meta.right_empty = (n_right == '0);
    end

    assign o_mem_addr = addr_w[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
        end else if (i_accept) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

endmodule

/* sv/two_stacks_shared_array_top.sv */
// two_stacks_shared_array_top: two LIFO stacks sharing one word store.
// Depends on tss_pkg, tss_ctrl and tss_mem.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_opcode, i_side_sel, i_push_value
//  out     | o_out_valid | i_out_ready | o_read_value, o_status, o_left_is_empty,
//          |             |             | o_right_is_empty, o_left_count, o_right_count
//
// One transaction per cycle sustained while the output is not stalled; a result
// passes the read stage (store read), then the output register.
// The depth counters update as a transaction is accepted, so the next one sees
// them at once; the store's one read or write port serves one access a cycle.
// Reset (i_rst_n low, synchronous) empties both stacks; no store clearing pass.
// A stalled output holds its result; one more transaction waits in the read
// stage, after which o_in_ready drops.
module two_stacks_shared_array_top #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tss_pkg::OpW-1:0]     i_opcode,
    input  logic                        i_side_sel,
    input  logic signed [31:0]          i_push_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_read_value,
    output logic [tss_pkg::StW-1:0]     o_status,
    output logic                        o_left_is_empty,
    output logic                        o_right_is_empty,
    output logic [tss_pkg::CntW-1:0]    o_left_count,
    output logic [tss_pkg::CntW-1:0]    o_right_count
);
    import tss_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic             accept;
    logic             s1_adv;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [WordW-1:0] mem_rdata;
    t_res_meta        meta;

    // Read stage: metadata waits here while the store read completes.
    logic             r_s1_vld;
    t_res_meta        r_s1_meta;

    // Output register.
    logic             r_out_vld;
    t_res_meta        r_out_meta;
    logic [WordW-1:0] r_out_rd;

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    tss_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_opcode   (i_opcode),
        .i_side_sel (i_side_sel),
        .o_mem_we   (mem_we),
        .o_mem_re   (mem_re),
        .o_mem_addr (mem_addr),
        .o_meta     (meta)
    );

    // A push writes at the accept edge; a later read of that entry samples the
    // array at a later edge, so no forwarding path is needed.
    tss_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_push_value),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Read data is held by the store until the next read, which cannot
    // happen before the read stage drains.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_meta <= r_s1_meta;
            r_out_rd   <= r_s1_meta.use_rd ? mem_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_read_value     = r_out_rd;
    assign o_status         = r_out_meta.status;
    assign o_left_is_empty  = r_out_meta.left_empty;
    assign o_right_is_empty = r_out_meta.right_empty;
    assign o_left_count     = r_out_meta.left_count;
    assign o_right_count    = r_out_meta.right_count;

endmodule

/* sv/tss_chk.sv */
// tss_chk: port-level checks for two_stacks_shared_array_top, bound below.
// Uses tss_pkg for status codes.
module tss_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [31:0]          o_read_value,
    input  logic [tss_pkg::StW-1:0]     o_status,
    input  logic                        o_left_is_empty,
    input  logic                        o_right_is_empty,
    input  logic [tss_pkg::CntW-1:0]    o_left_count,
    input  logic [tss_pkg::CntW-1:0]    o_right_count
);
    import tss_pkg::*;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_FULL))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_value == 32'sd0))
        else $error("failed transaction returned nonzero data");

    a_left_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_is_empty == (o_left_count == '0)))
        else $error("left empty flag disagrees with count");

    a_right_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_right_is_empty == (o_right_count == '0)))
        else $error("right empty flag disagrees with count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_value) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind two_stacks_shared_array_top tss_chk u_tss_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_read_value     (o_read_value),
    .o_status         (o_status),
    .o_left_is_empty  (o_left_is_empty),
    .o_right_is_empty (o_right_is_empty),
    .o_left_count     (o_left_count),
    .o_right_count    (o_right_count)
);

/* tb/testbench.sv */
// Self-checking bench for two_stacks_shared_array_top: random and directed stack
// operations against a behavioral copy of both stacks. Depends on tss_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import tss_pkg::*;

    localparam int unsigned DEPTH = 64;

    // One stack command as it goes into the block.
    typedef struct packed {
        logic [OpW-1:0]   op;
        logic             side;
        logic [WordW-1:0] value;
    } t_stack_cmd;

    // One result as the block should return it.
    typedef struct packed {
        logic [WordW-1:0] read_value;
        logic [StW-1:0]   status;
        logic             left_empty;
        logic             right_empty;
        logic [CntW-1:0]  left_count;
        logic [CntW-1:0]  right_count;
    } t_stack_result;

    // Shapes of a random burst: mostly pushes, mostly pops, or balanced.
    typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} t_burst_kind;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [OpW-1:0]         i_opcode = OP_TOP;
    logic                   i_side_sel = SIDE_LEFT;
    logic signed [31:0]     i_push_value = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [31:0]     o_read_value;
    logic [StW-1:0]         o_status;
    logic                   o_left_is_empty;
    logic                   o_right_is_empty;
    logic [CntW-1:0]        o_left_count;
    logic [CntW-1:0]        o_right_count;

    two_stacks_shared_array_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_side_sel      (i_side_sel),
        .i_push_value    (i_push_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_left_is_empty (o_left_is_empty),
        .o_right_is_empty(o_right_is_empty),
        .o_left_count    (o_left_count),
        .o_right_count   (o_right_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------
    // Behavioral copy of the two stacks. Left grows up from entry 0, right
    // grows down from DEPTH-1; they are full when the counts sum to DEPTH.
    // A failed command leaves everything as it was.
    // ---------------------------------------------------------------------
    logic [WordW-1:0] shadow_store [DEPTH];
    int unsigned      shadow_left  = 0;
    int unsigned      shadow_right = 0;

    task automatic apply_stack_cmd(input t_stack_cmd cmd, output t_stack_result res);
        int unsigned side_cnt;
        res = '0;
        side_cnt = (cmd.side == SIDE_RIGHT) ? shadow_right : shadow_left;
        case (cmd.op)
            OP_PUSH: begin
                if (shadow_left + shadow_right >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (cmd.side == SIDE_RIGHT) begin
                    shadow_store[DEPTH - 1 - shadow_right] = cmd.value;
                    shadow_right++;
                end else begin
                    shadow_store[shadow_left] = cmd.value;
                    shadow_left++;
                end
            end
            OP_POP, OP_TOP: begin
                if (side_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // top of the right stack is its lowest occupied entry
                    res.read_value = (cmd.side == SIDE_RIGHT) ? shadow_store[DEPTH - side_cnt]
                                                              : shadow_store[side_cnt - 1];
                    if (cmd.op == OP_POP) begin
                        if (cmd.side == SIDE_RIGHT) shadow_right--;
                        else shadow_left--;
                    end
                end
            end
            default: begin
                // clear: always ok, even on an empty side
                if (cmd.side == SIDE_RIGHT) shadow_right = 0;
                else shadow_left = 0;
            end
        endcase
        res.left_empty  = (shadow_left == 0);
        res.right_empty = (shadow_right == 0);
        res.left_count  = shadow_left[CntW-1:0];
        res.right_count = shadow_right[CntW-1:0];
    endtask

    // ---------------------------------------------------------------------
    // Queues and counters
    // ---------------------------------------------------------------------
    t_stack_cmd    pending_cmds[$];     // commands not yet offered to the block
    t_stack_result expected_results[$]; // predictions waiting for their result
    int unsigned   n_mismatch     = 0;
    int unsigned   send_idle_pct  = 12;
    int unsigned   recv_idle_pct  = 70;
    bit            in_taken       = 1'b0;
    bit            drive_enable   = 1'b0;

    // ---------------------------------------------------------------------
    // Driver: moves to a new command at the falling edge only once the one
    // on the port was taken, so valid and payload hold while stalled.
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_stack_cmd cmd;
        if (drive_enable && (!i_in_valid || in_taken)) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd = pending_cmds.pop_front();
                i_opcode     <= cmd.op;
                i_side_sel   <= cmd.side;
                i_push_value <= cmd.value;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid   <= 1'b0;
            end
        end
        in_taken = 1'b0;
        // receiver backpressure
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------------
    // Monitor: at the rising edge, predict each accepted transaction, then
    // check each result transaction against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stack_cmd    cmd;
        t_stack_result want;
        t_stack_result got;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            cmd.op    = i_opcode;
            cmd.side  = i_side_sel;
            cmd.value = i_push_value;
            apply_stack_cmd(cmd, want);
            expected_results.push_back(want);
            in_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.read_value  = o_read_value;
            got.status      = o_status;
            got.left_empty  = o_left_is_empty;
            got.right_empty = o_right_is_empty;
            got.left_count  = o_left_count;
            got.right_count = o_right_count;
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: result with nothing outstanding: rd=%h st=%0d",
                             $realtime, got.read_value, got.status);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"%0t: mismatch exp rd=%h st=%0d le=%b re=%b lc=%0d rc=%0d",
                                  " | got rd=%h st=%0d le=%b re=%b lc=%0d rc=%0d"},
                                 $realtime,
                                 want.read_value, want.status, want.left_empty,
                                 want.right_empty, want.left_count, want.right_count,
                                 got.read_value, got.status, got.left_empty,
                                 got.right_empty, got.left_count, got.right_count);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_cmd(input logic [OpW-1:0] op, input logic side,
                             input logic [WordW-1:0] value);
        t_stack_cmd cmd;
        cmd.op    = op;
        cmd.side  = side;
        cmd.value = value;
        pending_cmds.push_back(cmd);
    endtask

    // Bursts that drive the stacks to full and back to empty, so that both
    // failure cases and the meeting point of the stacks are hit often.
    task automatic queue_random(input int unsigned n_items);
        t_burst_kind kind;
        int unsigned burst_left;
        int unsigned right_pct;
        int unsigned roll;
        logic [OpW-1:0] op;
        burst_left = 0;
        kind       = BURST_MIXED;
        right_pct  = 50;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(160, 30);
                right_pct  = $urandom_range(90, 10);
                case ($urandom_range(2))
                    0:       kind = BURST_FILL;
                    1:       kind = BURST_DRAIN;
                    default: kind = BURST_MIXED;
                endcase
            end
            burst_left--;
            roll = $urandom_range(99);
            case (kind)
                BURST_FILL:  op = (roll < 85) ? OP_PUSH : (roll < 93) ? OP_POP :
                                  (roll < 99) ? OP_TOP : OP_CLEAR;
                BURST_DRAIN: op = (roll < 15) ? OP_PUSH : (roll < 75) ? OP_POP :
                                  (roll < 96) ? OP_TOP : OP_CLEAR;
                default:     op = (roll < 40) ? OP_PUSH : (roll < 70) ? OP_POP :
                                  (roll < 95) ? OP_TOP : OP_CLEAR;
            endcase
            queue_cmd(op, ($urandom_range(99) < right_pct) ? SIDE_RIGHT : SIDE_LEFT,
                      $urandom());
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n      <= 1'b1;
        drive_enable  = 1'b1;

        // directed: empty-side failures, clear of an empty side, word extremes,
        // LIFO order on both sides, clear of a loaded side
        queue_cmd(OP_POP,   SIDE_LEFT,  32'h1234_5678);
        queue_cmd(OP_TOP,   SIDE_RIGHT, 32'h0);
        queue_cmd(OP_POP,   SIDE_RIGHT, 32'hFFFF_FFFF);
        queue_cmd(OP_TOP,   SIDE_LEFT,  32'h0);
        queue_cmd(OP_CLEAR, SIDE_LEFT,  32'h0);
        queue_cmd(OP_CLEAR, SIDE_RIGHT, 32'h0);
        queue_cmd(OP_PUSH,  SIDE_LEFT,  32'h8000_0000);
        queue_cmd(OP_PUSH,  SIDE_LEFT,  32'h7FFF_FFFF);
        queue_cmd(OP_PUSH,  SIDE_RIGHT, 32'hFFFF_FFFF);
        queue_cmd(OP_PUSH,  SIDE_RIGHT, 32'h0000_0000);
        queue_cmd(OP_TOP,   SIDE_LEFT,  32'h0);
        queue_cmd(OP_TOP,   SIDE_RIGHT, 32'h0);
        queue_cmd(OP_POP,   SIDE_LEFT,  32'h0);
        queue_cmd(OP_POP,   SIDE_LEFT,  32'h0);
        queue_cmd(OP_POP,   SIDE_LEFT,  32'h0);
        queue_cmd(OP_POP,   SIDE_RIGHT, 32'h0);
        queue_cmd(OP_PUSH,  SIDE_LEFT,  32'hAAAA_AAAA);
        queue_cmd(OP_PUSH,  SIDE_LEFT,  32'h5555_5555);
        queue_cmd(OP_CLEAR, SIDE_LEFT,  32'h0);
        queue_cmd(OP_TOP,   SIDE_LEFT,  32'h0);
        queue_cmd(OP_TOP,   SIDE_RIGHT, 32'h0);
        queue_cmd(OP_CLEAR, SIDE_RIGHT, 32'h0);
        queue_cmd(OP_POP,   SIDE_RIGHT, 32'h0);

        // random, in three idling regimes: sender light / receiver heavy,
        // then the reverse, then back to back
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 12 : 0;
            queue_random(650);
            while (pending_cmds.size() > 0) @(posedge i_clk);
        end

        // drain: last command accepted, then every result back
        while (i_in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_mismatch == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule
